// ----- hdl/pfdrc_pkg.sv -----
// Shared types, constants and helpers for the deduplicating packet FIFO.
package pfdrc_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int CNT_W = 5;
	localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_FWD   = 2'd1;
	localparam logic [1:0] OP_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
		logic [31:0] start_time;
		logic [31:0] end_time;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        packet_valid;
		logic [15:0] out_source;
		logic [15:0] out_destination;
		logic [31:0] out_timestamp;
		logic [CNT_W-1:0] match_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
	} entry_t;

	typedef struct packed {
		logic start;
		logic rd;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             scan_done;
		logic [OCC_W-1:0] occ;
	} dp_status_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		if (idx == IDX_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + IDX_W'(1);
		end
		return nxt;
	endfunction

endpackage

// ----- hdl/pfdrc_ctrl.sv -----
// Controller state machine: accept, scan the held entries, commit and present the result.
module pfdrc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  pfdrc_pkg::dp_status_t  st,
	output pfdrc_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;

	assign cmd.start  = (state_q == S_IDLE) && req_valid;
	assign cmd.rd     = (state_q == S_SCAN) && !st.scan_done;
	assign cmd.finish = (state_q == S_DONE) && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// last read data is folded in on the edge that leaves this state
					if (st.scan_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/pfdrc_dp.sv -----
// Datapath: entry store, ring pointers, scan compare and result register.
module pfdrc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfdrc_pkg::req_t                req,
	output pfdrc_pkg::rsp_t                rsp,
	input  logic                           cfg_we,
	input  logic [pfdrc_pkg::CAP_W-1:0]    cfg_wdata,
	input  pfdrc_pkg::ctrl_cmd_t           cmd,
	output pfdrc_pkg::dp_status_t          st
);

	pfdrc_pkg::entry_t entry_q [pfdrc_pkg::DEPTH];

	logic [pfdrc_pkg::CAP_W-1:0] cap_q;
	logic [pfdrc_pkg::IDX_W-1:0] head_q;
	logic [pfdrc_pkg::IDX_W-1:0] tail_q;
	logic [pfdrc_pkg::OCC_W-1:0] occ_q;
	logic [pfdrc_pkg::IDX_W-1:0] pos_q;
	logic [pfdrc_pkg::OCC_W-1:0] left_q;
	logic                        match_q;
	logic [pfdrc_pkg::CNT_W-1:0] cnt_q;
	pfdrc_pkg::req_t             op_q;
	pfdrc_pkg::entry_t           rd_data_s1;
	logic                        rd_vld_s1;
	pfdrc_pkg::rsp_t             rsp_q;

	logic [pfdrc_pkg::LIM_W-1:0] lim;
	logic                        at_limit;
	logic                        hit_triple;
	logic                        hit_range;
	logic [pfdrc_pkg::OCC_W-1:0] scan_len;
	logic                        not_empty;
	logic                        do_add;
	pfdrc_pkg::rsp_t             rsp_d;

	assign not_empty = (occ_q != '0);

	always_comb begin
		lim = pfdrc_pkg::LIM_W'(cap_q);
		if (lim == '0) begin
			lim = pfdrc_pkg::LIM_W'(1);
		end
		if (lim > pfdrc_pkg::LIM_W'(pfdrc_pkg::DEPTH)) begin
			lim = pfdrc_pkg::LIM_W'(pfdrc_pkg::DEPTH);
		end
	end

	assign at_limit = (pfdrc_pkg::LIM_W'(occ_q) >= lim);

	always_comb begin
		case (req.operation) inside
			pfdrc_pkg::OP_ADD, pfdrc_pkg::OP_COUNT: scan_len = occ_q;
			pfdrc_pkg::OP_FWD: scan_len = not_empty ? pfdrc_pkg::OCC_W'(1) : '0;
			default: scan_len = '0;
		endcase
	end

	assign hit_triple = (rd_data_s1.source == op_q.source) &&
		(rd_data_s1.destination == op_q.destination) &&
		(rd_data_s1.timestamp == op_q.timestamp);
	assign hit_range = (rd_data_s1.destination == op_q.destination) &&
		(rd_data_s1.timestamp >= op_q.start_time) &&
		(rd_data_s1.timestamp <= op_q.end_time);

	assign do_add = cmd.finish && (op_q.operation == pfdrc_pkg::OP_ADD) && !match_q;

	assign st.scan_done = (left_q == '0);
	assign st.occ       = occ_q;
	assign rsp          = rsp_q;

	always_comb begin
		rsp_d = '0;
		case (op_q.operation)
			pfdrc_pkg::OP_ADD: rsp_d.accepted = !match_q;
			pfdrc_pkg::OP_FWD: begin
				if (not_empty) begin
					rsp_d.packet_valid    = 1'b1;
					rsp_d.out_source      = rd_data_s1.source;
					rsp_d.out_destination = rd_data_s1.destination;
					rsp_d.out_timestamp   = rd_data_s1.timestamp;
				end
			end
			pfdrc_pkg::OP_COUNT: rsp_d.match_count = cnt_q;
			default: ;
		endcase
	end

	// entry store: one write port at the tail, one registered read port
	always_ff @(posedge clk) begin
		if (do_add) begin
			entry_q[tail_q] <= '{source: op_q.source, destination: op_q.destination,
				timestamp: op_q.timestamp};
		end
		if (cmd.rd) begin
			rd_data_s1 <= entry_q[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= req;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= pfdrc_pkg::CAP_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			pos_q     <= '0;
			left_q    <= '0;
			match_q   <= 1'b0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end

			rd_vld_s1 <= cmd.rd;

			if (cmd.start) begin
				pos_q   <= head_q;
				left_q  <= scan_len;
				match_q <= 1'b0;
				cnt_q   <= '0;
			end else if (cmd.rd) begin
				pos_q  <= pfdrc_pkg::idx_next(pos_q);
				left_q <= left_q - pfdrc_pkg::OCC_W'(1);
			end

			if (rd_vld_s1) begin
				if (hit_triple) begin
					match_q <= 1'b1;
				end
				if (hit_range && (cnt_q != pfdrc_pkg::CNT_MAX)) begin
					cnt_q <= cnt_q + pfdrc_pkg::CNT_W'(1);
				end
			end

			if (do_add) begin
				// evict the oldest when at or above the limit; occupancy then holds
				if (at_limit && not_empty) begin
					head_q <= pfdrc_pkg::idx_next(head_q);
				end else begin
					occ_q <= occ_q + pfdrc_pkg::OCC_W'(1);
				end
				tail_q <= pfdrc_pkg::idx_next(tail_q);
			end else if (cmd.finish && (op_q.operation == pfdrc_pkg::OP_FWD) && not_empty) begin
				head_q <= pfdrc_pkg::idx_next(head_q);
				occ_q  <= occ_q - pfdrc_pkg::OCC_W'(1);
			end
		end
	end

endmodule

// ----- hdl/packet_fifo_dedup_range_count.sv -----
// Deduplicating bounded packet FIFO with forward and destination/time-range count.
// A request is taken only in the idle state; the scan then reads one held entry per cycle through the
// single store read port (every held entry for add and count, the head entry alone for forward, none
// when empty), and no new request is taken until the response has been registered.
// Reset: buffer empty, pointers zero, capacity limit 16; entry contents undefined.
module packet_fifo_dedup_range_count (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  pfdrc_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output pfdrc_pkg::rsp_t              rsp,
	input  logic                         cfg_we,
	input  logic [pfdrc_pkg::CAP_W-1:0]  cfg_wdata
);

	pfdrc_pkg::ctrl_cmd_t  cmd;
	pfdrc_pkg::dp_status_t st;

	pfdrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.st        (st),
		.cmd       (cmd)
	);

	pfdrc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st)
	);

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.occ <= pfdrc_pkg::OCC_W'(pfdrc_pkg::DEPTH))
		else $error("occupancy above buffer depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("new transaction taken while one is in flight");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.packet_valid) |-> (!rsp.accepted && rsp.match_count == '0))
		else $error("forward response carries add or count fields");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the deduplicating packet FIFO with range count.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int PHASES        = 8;

	typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		pfdrc_pkg::req_t             item;
		logic [pfdrc_pkg::CAP_W-1:0] limit;
		bit                          typed;
		pfdrc_pkg::rsp_t             want;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	pfdrc_pkg::req_t             req = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	pfdrc_pkg::rsp_t             rsp;
	logic                        cfg_we = 1'b0;
	logic [pfdrc_pkg::CAP_W-1:0] cfg_wdata = '0;

	// predictor state
	pfdrc_pkg::entry_t           held_pkt [pfdrc_pkg::DEPTH];
	int unsigned                 held_head, held_tail, held_count;
	logic [pfdrc_pkg::CAP_W-1:0] held_limit = pfdrc_pkg::CAP_RESET;
	logic [31:0]                 ts_now = 32'd100;

	pfdrc_pkg::rsp_t expected_rsp_q [$];
	stim_row_t       directed_rows [$];
	pfdrc_pkg::rsp_t got_want;
	bit              bursty = 1'b1;
	int              fail_count, reported, quiet_cycles;
	int              n_stored, n_refused, n_popped, n_empty_pops, n_counts;

	packet_fifo_dedup_range_count dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic pfdrc_pkg::rsp_t fifo_predict(input pfdrc_pkg::req_t r);
		pfdrc_pkg::rsp_t o;
		bit              dup;
		int unsigned     pos, lim, hits;
		o = '0;
		pos = held_head;
		case (r.operation)
			pfdrc_pkg::OP_ADD: begin
				dup = 1'b0;
				for (int k = 0; k < held_count; k++) begin
					if (held_pkt[pfdrc_pkg::IDX_W'(pos)] ==
					    {r.source, r.destination, r.timestamp})
						dup = 1'b1;
					pos = (pos + 1) % pfdrc_pkg::DEPTH;
				end
				if (!dup) begin
					lim = held_limit;
					if (lim == 0)
						lim = 1;
					if (lim > pfdrc_pkg::DEPTH)
						lim = pfdrc_pkg::DEPTH;
					// evict oldest silently when at or over the limit
					if (held_count >= lim && held_count != 0) begin
						held_head = (held_head + 1) % pfdrc_pkg::DEPTH;
						held_count--;
					end
					held_pkt[pfdrc_pkg::IDX_W'(held_tail)] =
						{r.source, r.destination, r.timestamp};
					held_tail = (held_tail + 1) % pfdrc_pkg::DEPTH;
					held_count++;
					o.accepted = 1'b1;
				end
			end
			pfdrc_pkg::OP_FWD: begin
				if (held_count != 0) begin
					o.packet_valid    = 1'b1;
					o.out_source      = held_pkt[pfdrc_pkg::IDX_W'(held_head)].source;
					o.out_destination = held_pkt[pfdrc_pkg::IDX_W'(held_head)].destination;
					o.out_timestamp   = held_pkt[pfdrc_pkg::IDX_W'(held_head)].timestamp;
					held_head = (held_head + 1) % pfdrc_pkg::DEPTH;
					held_count--;
				end
			end
			pfdrc_pkg::OP_COUNT: begin
				hits = 0;
				for (int k = 0; k < held_count; k++) begin
					if (held_pkt[pfdrc_pkg::IDX_W'(pos)].destination == r.destination &&
					    held_pkt[pfdrc_pkg::IDX_W'(pos)].timestamp >= r.start_time &&
					    held_pkt[pfdrc_pkg::IDX_W'(pos)].timestamp <= r.end_time)
						hits++;
					pos = (pos + 1) % pfdrc_pkg::DEPTH;
				end
				o.match_count = (hits > pfdrc_pkg::CNT_MAX) ? pfdrc_pkg::CNT_MAX :
					pfdrc_pkg::CNT_W'(hits);
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic pfdrc_pkg::req_t packet_req(input logic [1:0] op,
		input logic [15:0] s, input logic [15:0] d, input logic [31:0] t,
		input logic [31:0] lo, input logic [31:0] hi);
		pfdrc_pkg::req_t r;
		r.operation   = op;
		r.source      = s;
		r.destination = d;
		r.timestamp   = t;
		r.start_time  = lo;
		r.end_time    = hi;
		return r;
	endfunction

	function automatic pfdrc_pkg::rsp_t rsp_fields(input bit acc, input bit pv,
		input logic [15:0] s, input logic [15:0] d, input logic [31:0] t);
		pfdrc_pkg::rsp_t o;
		o = '0;
		o.accepted        = acc;
		o.packet_valid    = pv;
		o.out_source      = s;
		o.out_destination = d;
		o.out_timestamp   = t;
		return o;
	endfunction

	task automatic row_item(input pfdrc_pkg::req_t r, input bit typed,
		input pfdrc_pkg::rsp_t want);
		stim_row_t row;
		row = '{ROW_ITEM, r, '0, typed, want};
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic row_limit(input logic [pfdrc_pkg::CAP_W-1:0] v);
		stim_row_t row;
		row = '{ROW_LIMIT, '0, v, 1'b0, '0};
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic pfdrc_pkg::req_t random_item();
		pfdrc_pkg::req_t   r;
		pfdrc_pkg::entry_t e;
		int unsigned       pick;
		logic [31:0]       swap;
		pick = $urandom_range(0, 99);
		r.operation   = (pick < 50) ? pfdrc_pkg::OP_ADD : (pick < 70) ? pfdrc_pkg::OP_FWD :
		                (pick < 96) ? pfdrc_pkg::OP_COUNT : OP_UNUSED;
		r.source      = 16'($urandom);
		r.destination = 16'($urandom);
		r.timestamp   = $urandom;
		r.start_time  = $urandom;
		r.end_time    = $urandom;
		if ($urandom_range(0, 9) != 0) begin
			// small address pools and a slowly advancing clock make collisions likely
			r.source      = 16'($urandom_range(0, 3));
			r.destination = 16'($urandom_range(0, 3));
			ts_now        = ts_now + $urandom_range(0, 2);
			r.timestamp   = ts_now;
			r.start_time  = ts_now - $urandom_range(0, 24);
			r.end_time    = r.start_time + $urandom_range(0, 24);
			if ($urandom_range(0, 15) == 0) begin
				swap         = r.start_time;
				r.start_time = r.end_time;
				r.end_time   = swap;
			end
		end
		if (held_count != 0 && $urandom_range(0, 4) == 0) begin
			e = held_pkt[pfdrc_pkg::IDX_W'((held_head + $urandom_range(0, held_count - 1)) %
				pfdrc_pkg::DEPTH)];
			r.source      = e.source;
			r.destination = e.destination;
			r.timestamp   = e.timestamp;
			if ($urandom_range(0, 1) == 0) begin
				r.start_time = '0;
				r.end_time   = '1;
			end
		end
		return r;
	endfunction

	// hold the transaction until taken, then log what it should return
	task automatic issue(input pfdrc_pkg::req_t r, input bit typed,
		input pfdrc_pkg::rsp_t want);
		pfdrc_pkg::rsp_t predicted;
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predicted = fifo_predict(r);
		expected_rsp_q.insert(expected_rsp_q.size(), typed ? want : predicted);
		if (r.operation == pfdrc_pkg::OP_ADD && predicted.accepted)
			n_stored++;
		if (r.operation == pfdrc_pkg::OP_ADD && !predicted.accepted)
			n_refused++;
		if (r.operation == pfdrc_pkg::OP_FWD && predicted.packet_valid)
			n_popped++;
		if (r.operation == pfdrc_pkg::OP_FWD && !predicted.packet_valid)
			n_empty_pops++;
		if (r.operation == pfdrc_pkg::OP_COUNT && predicted.match_count != 0)
			n_counts++;
		if (bursty && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// drain everything outstanding before touching the register
	task automatic write_limit(input logic [pfdrc_pkg::CAP_W-1:0] v);
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		held_limit = v;
	endtask

	always begin
		@(posedge clk);
		if (bursty && $urandom_range(0, 11) == 0) begin
			rsp_stall <= 1'b1;
			repeat ($urandom_range(1, 18)) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				fail_count++;
				if (reported < 10) begin
					$display("unexpected response: acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
						rsp.accepted, rsp.packet_valid, rsp.out_source,
						rsp.out_destination, rsp.out_timestamp, rsp.match_count);
					reported++;
				end
			end else begin
				got_want = expected_rsp_q.pop_front();
				if (rsp.accepted !== got_want.accepted ||
				    rsp.packet_valid !== got_want.packet_valid ||
				    rsp.out_source !== got_want.out_source ||
				    rsp.out_destination !== got_want.out_destination ||
				    rsp.out_timestamp !== got_want.out_timestamp ||
				    rsp.match_count !== got_want.match_count) begin
					fail_count++;
					if (reported < 10) begin
						$display("mismatch: expected acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
							got_want.accepted, got_want.packet_valid, got_want.out_source,
							got_want.out_destination, got_want.out_timestamp,
							got_want.match_count);
						$display("          actual   acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
							rsp.accepted, rsp.packet_valid, rsp.out_source,
							rsp.out_destination, rsp.out_timestamp, rsp.match_count);
						reported++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("packet_fifo_dedup_range_count verification failed");
			$finish;
		end
	end

	initial begin
		logic [pfdrc_pkg::CAP_W-1:0] phase_limit [PHASES];
		int                          done;
		pfdrc_pkg::req_t             r;

		phase_limit = '{5'd31, 5'd4, 5'd1, 5'd0, 5'd16, 5'd9, 5'd2, 5'd16};
		phase_limit[5] = pfdrc_pkg::CAP_W'($urandom_range(2, 15));

		row_item(packet_req(pfdrc_pkg::OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1, '0);
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, '1), 1'b1, '0);
		row_item(packet_req(OP_UNUSED, '1, '1, '1, '1, '1), 1'b1, '0);
		row_item(packet_req(pfdrc_pkg::OP_ADD, '1, '1, '1, 32'h0, 32'h0), 1'b1,
			rsp_fields(1'b1, 1'b0, 16'h0, 16'h0, 32'h0));
		row_item(packet_req(pfdrc_pkg::OP_ADD, '1, '1, '1, 32'h0, 32'h0), 1'b1, '0);
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h0, 16'h0, 32'h0, '1, '1), 1'b1,
			rsp_fields(1'b1, 1'b0, 16'h0, 16'h0, 32'h0));
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h0, '1, 32'h0, 32'h0, 32'h0), 1'b1,
			rsp_fields(1'b1, 1'b0, 16'h0, 16'h0, 32'h0));
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h1, '1, '1, 32'h0, 32'h0), 1'b1,
			rsp_fields(1'b1, 1'b0, 16'h0, 16'h0, 32'h0));
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, '1, 32'h0, 32'h0, '1), 1'b0, '0);
		// inverted window never matches
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, '1, 32'h0, '1, 32'h0), 1'b1, '0);
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, '1, 32'h0, '1, '1), 1'b0, '0);
		// timestamp going backwards is still stored and counted
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h2, '1, 32'h5, 32'h0, 32'h0), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, '1, 32'h0, 32'h0, 32'h5), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1,
			rsp_fields(1'b0, 1'b1, '1, '1, '1));
		row_item(packet_req(pfdrc_pkg::OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
		// a zero limit behaves as one; occupancy already sits above it
		row_limit(5'd0);
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h7, 16'h7, 32'd10, 32'h0, 32'h0), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h8, 16'h7, 32'd11, 32'h0, 32'h0), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, 16'h7, 32'h0, 32'd10, 32'd11),
			1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
		row_limit(5'd31);
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 32'h0,
			32'h0), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_ADD, 16'hAAAA, 16'h5555, 32'hAAAA_5555, 32'h0,
			32'h0), 1'b0, '0);
		row_item(packet_req(pfdrc_pkg::OP_COUNT, 16'h0, 16'hAAAA, 32'h0, 32'h5555_AAAA,
			32'h5555_AAAA), 1'b0, '0);

		for (int k = 0; k < pfdrc_pkg::DEPTH; k++)
			held_pkt[k] = '0;
		held_head  = 0;
		held_tail  = 0;
		held_count = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT)
				write_limit(directed_rows[i].limit);
			else
				issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			if (p == PHASES - 1)
				bursty = 1'b0;
			done = 0;
			while (done < RANDOM_ITEMS / PHASES) begin
				r = random_item();
				issue(r, 1'b0, '0);
				done++;
			end
		end

		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d stores, %0d duplicate refusals, %0d pops, %0d empty pops",
			n_stored, n_refused, n_popped, n_empty_pops);
		$display("%0d range counts with hits, capacity limits from 0 to 31, %0d errors",
			n_counts, fail_count);
		if (fail_count == 0)
			$display("packet_fifo_dedup_range_count verification clean");
		else
			$display("packet_fifo_dedup_range_count verification failed");
		$finish;
	end

endmodule
